// ===== sv/byte_fifo_with_pattern_search_macros.svh =====
`ifndef BYTE_FIFO_WITH_PATTERN_SEARCH_MACROS_SVH
`define BYTE_FIFO_WITH_PATTERN_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfps assertion failed");

// next-cycle implication, checked outside reset
`define BFPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfps assertion failed");

`endif

// ===== sv/bfps_pkg.sv =====
package bfps_pkg;

    localparam int DEPTH       = 4096;
    localparam int PATTERN_MAX = 16;
    localparam int POP_MAX     = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = 13;
    localparam int POS_W       = 63;
    localparam int LEN_W       = 5;

    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] POP_MAX_C = CNT_W'(POP_MAX);
    localparam logic [LEN_W-1:0] PAT_MAX_C = LEN_W'(PATTERN_MAX);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_DROP   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] REG_LEN  = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    typedef logic [7:0] byte_t;

    function automatic byte_t pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [3:0] j);
        logic [127:0] all;
        all = {hi, lo};
        return all[{j, 3'b000} +: 8];
    endfunction

endpackage

// ===== sv/byte_fifo_with_pattern_search.sv =====
// Push and drop: ST_PUSH or ST_DROP, then ST_ONE. Pop: ST_POP_RD reads, ST_POP_EM
// emits each byte, n results; a pop moving nothing goes to ST_ONE. Search: after
// ST_CLAMP and ST_REL, per start position tried ST_CHK, then per compared byte ST_RD
// (one RAM read) and ST_CMP; ST_ONE registers the result. One operation at a time;
// the next beat is taken once the result is registered. aresetn (synchronous,
// active low) empties the queue and clears the pattern.
module byte_fifo_with_pattern_search (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [87:0]   s_tdata,   // push_byte, count, restart_position, use_restart
    input  logic [1:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // out_byte, moved_count, found, match_offset,
                                     // restart_out, fill_level, overflow
    output logic          m_tuser,   // byte_valid
    output logic          m_tlast
);
    import bfps_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PUSH   = 4'd1;
    localparam logic [3:0] ST_POP_RD = 4'd2;
    localparam logic [3:0] ST_POP_EM = 4'd3;
    localparam logic [3:0] ST_DROP   = 4'd4;
    localparam logic [3:0] ST_CLAMP  = 4'd5;
    localparam logic [3:0] ST_REL    = 4'd6;
    localparam logic [3:0] ST_CHK    = 4'd7;
    localparam logic [3:0] ST_RD     = 4'd8;
    localparam logic [3:0] ST_CMP    = 4'd9;
    localparam logic [3:0] ST_ONE    = 4'd10;

    logic [3:0]        state_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [63:0]       plo_reg, phi_reg;
    logic [ADDR_W-1:0] head_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [POS_W-1:0]  hpos_reg;

    byte_t             byte_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  start_reg;
    logic [CNT_W-1:0]  n_reg, i_reg, pfill_reg, m_reg;
    logic [LEN_W-1:0]  j_reg, len_reg;

    logic [CNT_W-1:0]  res_moved_reg;
    logic              res_found_reg, res_ovf_reg;
    logic [ADDR_W-1:0] res_off_reg;
    logic [POS_W-1:0]  res_rs_reg;

    logic              mv_reg, mlast_reg, mbv_reg, mfound_reg, movf_reg;
    byte_t             mbyte_reg;
    logic [CNT_W-1:0]  mmoved_reg, mfill_reg;
    logic [ADDR_W-1:0] moff_reg;
    logic [POS_W-1:0]  mrs_reg;

    logic              out_free;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    byte_t             rd_data;
    logic [CNT_W-1:0]  in_count, cnt_sat, pop_n;
    logic [POS_W-1:0]  in_rpos, rel;
    logic [LEN_W-1:0]  len_sat;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_count = s_tdata[20:8];
    assign in_rpos  = s_tdata[83:21];
    assign cnt_sat  = (in_count > POP_MAX_C) ? POP_MAX_C : in_count;
    assign pop_n    = (cnt_sat < fill_reg) ? cnt_sat : fill_reg;
    assign len_sat  = (plen_reg > PAT_MAX_C) ? PAT_MAX_C : plen_reg;
    assign rel      = start_reg - hpos_reg;

    assign wr_en   = (state_reg == ST_PUSH) && (fill_reg != DEPTH_C);
    assign wr_addr = head_reg + fill_reg[ADDR_W-1:0];
    assign rd_en   = (state_reg == ST_POP_RD) || (state_reg == ST_RD);
    assign rd_addr = (state_reg == ST_RD)
                   ? head_reg + m_reg[ADDR_W-1:0] + ADDR_W'(j_reg) : head_reg;

    bfps_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            plen_reg  <= '0;
            plo_reg   <= '0;
            phi_reg   <= '0;
            head_reg  <= '0;
            fill_reg  <= '0;
            hpos_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_POP_EM && state_reg != ST_ONE) begin
                mv_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LEN:  plen_reg <= cfg_wdata[LEN_W-1:0];
                    REG_LOW:  plo_reg  <= cfg_wdata;
                    REG_HIGH: phi_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        byte_reg      <= s_tdata[7:0];
                        count_reg     <= in_count;
                        start_reg     <= s_tdata[84] ? in_rpos : hpos_reg;
                        len_reg       <= len_sat;
                        res_moved_reg <= '0;
                        res_found_reg <= 1'b0;
                        res_ovf_reg   <= 1'b0;
                        res_off_reg   <= '0;
                        res_rs_reg    <= '0;
                        n_reg         <= pop_n;
                        i_reg         <= '0;
                        pfill_reg     <= fill_reg - pop_n;
                        unique case (s_tuser)
                            OP_PUSH: state_reg <= ST_PUSH;
                            OP_POP:  state_reg <= (pop_n == '0) ? ST_ONE : ST_POP_RD;
                            OP_DROP: state_reg <= ST_DROP;
                            default: state_reg <= ST_CLAMP;
                        endcase
                    end
                end
                ST_PUSH: begin
                    if (fill_reg == DEPTH_C) begin
                        res_ovf_reg <= 1'b1;
                    end else begin
                        fill_reg      <= fill_reg + 1'b1;
                        res_moved_reg <= CNT_W'(1);
                    end
                    state_reg <= ST_ONE;
                end
                ST_DROP: begin
                    if (count_reg < fill_reg) begin
                        head_reg      <= head_reg + count_reg[ADDR_W-1:0];
                        fill_reg      <= fill_reg - count_reg;
                        hpos_reg      <= hpos_reg + POS_W'(count_reg);
                        res_moved_reg <= count_reg;
                    end else begin
                        head_reg      <= head_reg + fill_reg[ADDR_W-1:0];
                        fill_reg      <= '0;
                        hpos_reg      <= hpos_reg + POS_W'(fill_reg);
                        res_moved_reg <= fill_reg;
                    end
                    state_reg <= ST_ONE;
                end
                ST_POP_RD: begin
                    state_reg <= ST_POP_EM;
                end
                ST_POP_EM: begin
                    if (out_free) begin
                        mv_reg     <= 1'b1;
                        mbyte_reg  <= rd_data;
                        mbv_reg    <= 1'b1;
                        mlast_reg  <= (i_reg + 1'b1 == n_reg);
                        mmoved_reg <= n_reg;
                        mfound_reg <= 1'b0;
                        moff_reg   <= '0;
                        mrs_reg    <= '0;
                        mfill_reg  <= pfill_reg;
                        movf_reg   <= 1'b0;
                        head_reg   <= head_reg + 1'b1;
                        fill_reg   <= fill_reg - 1'b1;
                        hpos_reg   <= hpos_reg + 1'b1;
                        i_reg      <= i_reg + 1'b1;
                        state_reg  <= (i_reg + 1'b1 == n_reg) ? ST_IDLE : ST_POP_RD;
                    end
                end
                ST_CLAMP: begin
                    if (len_reg == '0) begin
                        res_found_reg <= 1'b1;
                        res_rs_reg    <= start_reg;
                        state_reg     <= ST_ONE;
                    end else begin
                        if (start_reg < hpos_reg) begin
                            start_reg <= hpos_reg;
                        end
                        state_reg <= ST_REL;
                    end
                end
                ST_REL: begin
                    if (rel >= POS_W'(fill_reg)) begin
                        res_rs_reg <= start_reg;
                        state_reg  <= ST_ONE;
                    end else begin
                        m_reg     <= rel[CNT_W-1:0];
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if ((fill_reg - m_reg) < CNT_W'(len_reg)) begin
                        res_rs_reg <= hpos_reg + POS_W'(m_reg);
                        state_reg  <= ST_ONE;
                    end else begin
                        j_reg     <= '0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (rd_data != pat_byte(plo_reg, phi_reg, j_reg[3:0])) begin
                        m_reg     <= m_reg + 1'b1;
                        state_reg <= ST_CHK;
                    end else if (j_reg + 1'b1 == len_reg) begin
                        res_found_reg <= 1'b1;
                        res_off_reg   <= m_reg[ADDR_W-1:0];
                        res_rs_reg    <= hpos_reg + POS_W'(m_reg);
                        state_reg     <= ST_ONE;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_ONE: begin
                    if (out_free) begin
                        mv_reg     <= 1'b1;
                        mbyte_reg  <= '0;
                        mbv_reg    <= 1'b0;
                        mlast_reg  <= 1'b1;
                        mmoved_reg <= res_moved_reg;
                        mfound_reg <= res_found_reg;
                        moff_reg   <= res_off_reg;
                        mrs_reg    <= res_rs_reg;
                        mfill_reg  <= fill_reg;
                        movf_reg   <= res_ovf_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mbv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {1'b0, movf_reg, mfill_reg, mrs_reg, moff_reg, mfound_reg,
                       mmoved_reg, mbyte_reg};

`include "byte_fifo_with_pattern_search_macros.svh"

    `BFPS_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= DEPTH_C)
    `BFPS_ASSERT_IMP(a_ovf_full, aclk, aresetn, mv_reg && movf_reg, mfill_reg == DEPTH_C)
    `BFPS_ASSERT_IMP(a_byte_moved, aclk, aresetn, mv_reg && mbv_reg, mmoved_reg != '0)
    `BFPS_ASSERT_NXT(a_push_grow, aclk, aresetn,
                     state_reg == ST_PUSH && fill_reg != DEPTH_C,
                     fill_reg == $past(fill_reg) + 1'b1)

endmodule

// ===== sv/bfps_ram.sv =====
module bfps_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [bfps_pkg::ADDR_W-1:0] wr_addr,
    input  bfps_pkg::byte_t             wr_data,
    input  logic                        rd_en,
    input  logic [bfps_pkg::ADDR_W-1:0] rd_addr,
    output bfps_pkg::byte_t             rd_data
);
    import bfps_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/bfps_checker.sv =====
`timescale 1ns / 100ps

module bfps_checker
    import bfps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [87:0]  s_tdata,   // push_byte, count, restart_position, use_restart
    input  logic [1:0]   s_tuser,   // op
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,   // out_byte, moved_count, found, match_offset,
                                    // restart_out, fill_level, overflow
    input  logic         m_tuser,   // byte_valid
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             last;
        logic [CNT_W-1:0] moved;
        logic             found;
        logic [11:0]      offset;
        logic [POS_W-1:0] restart;
        logic [CNT_W-1:0] fill;
        logic             overflow;
    } fifo_result_t;

    fifo_result_t     expected_results[$];
    logic [7:0]       ring[DEPTH];
    logic [11:0]      head;
    logic [CNT_W-1:0] fill;
    logic [POS_W-1:0] head_pos;
    logic [LEN_W-1:0] pat_len;
    logic [63:0]      pat_lo;
    logic [63:0]      pat_hi;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic fifo_result_t blank_result();
        fifo_result_t r;
        r = '0;
        r.last = 1'b1;
        r.fill = fill;
        return r;
    endfunction

    function automatic logic [7:0] pattern_at(input int k);
        logic [127:0] all;
        all = {pat_hi, pat_lo};
        return all[k*8 +: 8];
    endfunction

    task automatic take_from_head(input int n);
        head     = head + 12'(n);
        fill     = fill - CNT_W'(n);
        head_pos = head_pos + POS_W'(n);
    endtask

    task automatic predict_search(input logic ur, input logic [POS_W-1:0] rpos);
        fifo_result_t r;
        int len;
        int m;
        int j;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] rel;
        r     = blank_result();
        len   = (pat_len > PAT_MAX_C) ? PATTERN_MAX : int'(pat_len);
        start = ur ? rpos : head_pos;
        if (len == 0) begin
            r.found   = 1'b1;
            r.restart = start;
            expected_results.push_back(r);
            return;
        end
        if (start < head_pos) start = head_pos;
        rel = start - head_pos;
        if (rel >= POS_W'(fill)) begin
            r.restart = start;
            expected_results.push_back(r);
            return;
        end
        r.restart = head_pos + POS_W'(fill);
        for (m = int'(rel); m < int'(fill); m++) begin
            if (int'(fill) - m < len) begin
                r.restart = head_pos + POS_W'(m);
                break;
            end
            for (j = 0; j < len; j++)
                if (ring[(int'(head) + m + j) % DEPTH] != pattern_at(j)) break;
            if (j == len) begin
                r.found   = 1'b1;
                r.offset  = 12'(m);
                r.restart = head_pos + POS_W'(m);
                break;
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic predict_beat(input logic [1:0] op, input logic [87:0] d);
        fifo_result_t r;
        logic [7:0] taken[POP_MAX];
        int n;
        int want;
        int i;
        case (op)
            OP_PUSH: begin
                if (fill >= DEPTH_C) begin
                    r = blank_result();
                    r.overflow = 1'b1;
                end else begin
                    ring[(int'(head) + int'(fill)) % DEPTH] = d[7:0];
                    fill++;
                    r = blank_result();
                    r.moved = CNT_W'(1);
                end
                expected_results.push_back(r);
            end
            OP_POP: begin
                want = int'(d[20:8]);
                if (want > POP_MAX) want = POP_MAX;
                n = (want < int'(fill)) ? want : int'(fill);
                for (i = 0; i < n; i++) taken[i] = ring[(int'(head) + i) % DEPTH];
                take_from_head(n);
                if (n == 0) expected_results.push_back(blank_result());
                for (i = 0; i < n; i++) begin
                    r = blank_result();
                    r.out_byte   = taken[i];
                    r.byte_valid = 1'b1;
                    r.last       = (i == n - 1);
                    r.moved      = CNT_W'(n);
                    expected_results.push_back(r);
                end
            end
            OP_DROP: begin
                want = int'(d[20:8]);
                n = (want < int'(fill)) ? want : int'(fill);
                take_from_head(n);
                r = blank_result();
                r.moved = CNT_W'(n);
                expected_results.push_back(r);
            end
            default: predict_search(d[84], d[83:21]);
        endcase
    endtask

    task automatic compare_beat();
        fifo_result_t w;
        if (expected_results.size() == 0) begin
            report("unexpected beat", m_tdata[63:0], '0);
            return;
        end
        w = expected_results.pop_front();
        if (m_tdata[7:0] !== w.out_byte)
            report("out_byte", 64'(m_tdata[7:0]), 64'(w.out_byte));
        if (m_tuser !== w.byte_valid)
            report("byte_valid", 64'(m_tuser), 64'(w.byte_valid));
        if (m_tlast !== w.last)
            report("last", 64'(m_tlast), 64'(w.last));
        if (m_tdata[20:8] !== w.moved)
            report("moved_count", 64'(m_tdata[20:8]), 64'(w.moved));
        if (m_tdata[21] !== w.found)
            report("found", 64'(m_tdata[21]), 64'(w.found));
        if (m_tdata[33:22] !== w.offset)
            report("match_offset", 64'(m_tdata[33:22]), 64'(w.offset));
        if (m_tdata[96:34] !== w.restart)
            report("restart_out", 64'(m_tdata[96:34]), 64'(w.restart));
        if (m_tdata[109:97] !== w.fill)
            report("fill_level", 64'(m_tdata[109:97]), 64'(w.fill));
        if (m_tdata[110] !== w.overflow)
            report("overflow", 64'(m_tdata[110]), 64'(w.overflow));
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            head     = '0;
            fill     = '0;
            head_pos = '0;
            pat_len  = '0;
            pat_lo   = '0;
            pat_hi   = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LEN:  pat_len = cfg_wdata[LEN_W-1:0];
                    REG_LOW:  pat_lo  = cfg_wdata;
                    REG_HIGH: pat_hi  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) compare_beat();
            if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bfps_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;   // push_byte, count, restart_position, use_restart
    logic [1:0]   s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // out_byte, moved_count, found, match_offset,
                             // restart_out, fill_level, overflow
    logic         m_tuser;   // byte_valid
    logic         m_tlast;
    int           errors;
    int           pending;
    bit           calm_on;
    bit           hold_go;
    bit           hold_done;
    logic [127:0] pattern;
    int           plen;

    byte_fifo_with_pattern_search dut (.*);

    bfps_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit calm();
        return calm_on;
    endfunction

    // receiver: random stalls, one long hold-off, one stretch without stalls
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= calm() || $urandom_range(99) >= 22;
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] pb,
                             input logic [12:0] cnt, input logic [62:0] rpos,
                             input logic ur);
        if (!calm() && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, ur, rpos, cnt, pb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_pattern(input int len, input logic [127:0] pat);
        settle();
        write_reg(REG_LEN, 64'(len));
        write_reg(REG_LOW, pat[63:0]);
        write_reg(REG_HIGH, pat[127:64]);
        pattern = pat;
        plen = (len > PATTERN_MAX) ? PATTERN_MAX : len;
    endtask

    function automatic logic [62:0] rand_pos();
        return 63'({$urandom, $urandom} >> 1);
    endfunction

    task automatic push_pattern();
        int k;
        for (k = 0; k < plen; k++) send_beat(OP_PUSH, pattern[k*8 +: 8], '0, '0, 1'b0);
    endtask

    task automatic random_beat();
        int sel;
        logic [7:0] pb;
        logic [12:0] cnt;
        logic [62:0] rpos;
        logic ur;
        sel = $urandom_range(99);
        pb = (plen > 0 && $urandom_range(9) < 8) ?
             pattern[$urandom_range(plen - 1)*8 +: 8] : 8'($urandom);
        cnt = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 20));
        rpos = ($urandom_range(4) == 0) ? rand_pos() : 63'($urandom_range(0, 600));
        ur = 1'($urandom);
        if (sel < 8) push_pattern();
        else if (sel < 48) send_beat(OP_PUSH, pb, cnt, rpos, ur);
        else if (sel < 63) send_beat(OP_POP, pb, cnt, rpos, ur);
        else if (sel < 75) send_beat(OP_DROP, pb, cnt, rpos, ur);
        else send_beat(OP_SEARCH, pb, cnt, rpos, ur);
    endtask

    initial begin
        int i;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PUSH;
        pattern   = '0;
        plen      = 0;
        calm_on   = 1'b0;
        hold_go   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue, empty pattern
        send_beat(OP_POP, 8'h00, 13'd5, '0, 1'b0);
        send_beat(OP_DROP, 8'h00, 13'h1FFF, '0, 1'b0);
        send_beat(OP_SEARCH, 8'h00, '0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_beat(OP_SEARCH, 8'hFF, '0, 63'd7, 1'b0);
        send_beat(OP_PUSH, 8'h00, '0, '0, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 13'h1FFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_beat(OP_POP, 8'h00, 13'd0, '0, 1'b0);
        send_beat(OP_POP, 8'h00, 13'd1, '0, 1'b0);

        load_pattern(3, 128'h00_00_00_00_00_00_00_00_00_00_00_00_00_C3_B2_A1);
        push_pattern();
        send_beat(OP_PUSH, 8'hA1, '0, '0, 1'b0);
        send_beat(OP_PUSH, 8'hB2, '0, '0, 1'b0);
        send_beat(OP_SEARCH, 8'h00, '0, 63'd0, 1'b1);
        send_beat(OP_SEARCH, 8'h00, '0, 63'd3, 1'b1);
        send_beat(OP_SEARCH, 8'h00, '0, 63'd50, 1'b1);
        send_beat(OP_DROP, 8'h00, 13'd1, '0, 1'b0);
        send_beat(OP_SEARCH, 8'h00, '0, 63'd0, 1'b1);
        send_beat(OP_SEARCH, 8'h00, '0, '0, 1'b0);

        // hold off the receiver while pushes keep coming, then drain
        load_pattern(16, {$urandom, $urandom, $urandom, $urandom});
        hold_go = 1'b1;
        for (i = 0; i < 20; i++) send_beat(OP_PUSH, 8'($urandom), '0, '0, 1'b0);
        send_beat(OP_SEARCH, 8'h00, '0, '0, 1'b0);
        send_beat(OP_POP, 8'h00, 13'd100, '0, 1'b0);
        send_beat(OP_DROP, 8'h00, 13'h1FFF, '0, 1'b0);

        load_pattern(1, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF5A});
        for (i = 0; i < 15; i++) random_beat();
        load_pattern(31, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        calm_on = 1'b1;
        for (i = 0; i < 15; i++) random_beat();
        calm_on = 1'b0;
        load_pattern(4, {$urandom, $urandom, 32'h0, 32'h3C3C_5AA5});
        for (i = 0; i < 15; i++) random_beat();
        load_pattern(16, {64'h0, 64'h0});
        for (i = 0; i < 15; i++) random_beat();
        load_pattern(0, {$urandom, $urandom, $urandom, $urandom});
        for (i = 0; i < 15; i++) random_beat();

        settle();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bfps_pkg.sv
sv/bfps_ram.sv
sv/byte_fifo_with_pattern_search.sv
verif/bfps_checker.sv
verif/tb.sv
